FILE: rtl/core/dgot_pkg.sv
package dgot_pkg;

  // Window storage depth, default for the top level
  localparam int unsigned WindowDepth = 512;

  // Fixed-point limits
  localparam logic [23:0] Q24Max  = 24'hFF_FFFF;
  localparam logic [23:0] GainOne = 24'd65536;
  localparam logic [16:0] WOne    = 17'd65536;

  // Accumulated window totals (sized for a window of up to 1024 frames)
  localparam int unsigned MeanTotW = 34;
  localparam int unsigned MsqTotW  = 58;

  // Shared divider and square root unit sizes
  localparam int unsigned DivW  = 72;
  localparam int unsigned DvsW  = 25;
  localparam int unsigned SqrtW = 64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PIXEL_COUNT   = 3'd0,
    CFG_SAMPLE_BITS   = 3'd1,
    CFG_WINDOW_FRAMES = 3'd2,
    CFG_CUT_THRESHOLD = 3'd3,
    CFG_DAMPING       = 3'd4,
    CFG_CHROMA_EN     = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_MEAN, ST_EX2, ST_M2, ST_VAR, ST_SIG,
    ST_WM, ST_WSQ, ST_WM2, ST_WS, ST_CUT1, ST_CUT2, ST_CUT3,
    ST_DROP, ST_DRD, ST_DSQ, ST_APPEND,
    ST_RMU, ST_RSIG, ST_GDIV, ST_GSQ, ST_GM, ST_OFF,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_FIN
  } state_e;

endpackage

FILE: rtl/core/deflicker_gain_offset_tracker.sv
// Deflicker gain/offset tracker. Each input item is one frame's luma sum and
// sum of squares; each produces one result item with a Q8.16 gain, a signed
// Q.8 offset, a scene-cut flag and a chroma-apply flag. The frame mean and
// sigma are compared against a rolling window of up to WINDOW_DEPTH frames
// (kept in an on-chip RAM); a scene cut passes the frame through with gain
// 1.0 and leaves the window untouched. All arithmetic runs on one restoring
// divider (one quotient bit per cycle), one digit-by-digit square root (two
// radicand bits per cycle) and one registered multiplier, stepped by a
// sequencer. An item runs the frame statistics, then the cut test once five
// frames are in the window, then drops the oldest window entries, appends
// the frame and computes the gain, with damping once an earlier non-cut
// result exists. Input is not taken while an item is in work; a finished
// result waits in the output register while the next item enters.
// Configuration writes are always accepted and must happen while idle.
module deflicker_gain_offset_tracker #(
  parameter int unsigned WINDOW_DEPTH = dgot_pkg::WindowDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [24:0]  cfg_data_i,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // [39:0] frame_sum, [95:40] frame_sum_sq
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [23:0] gain, [59:24] offset, [63:60] zero
  output logic [1:0]   m_axis_tuser    // [0] scene_cut, [1] chroma_apply
);

  localparam int unsigned HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned MTW = dgot_pkg::MeanTotW;
  localparam int unsigned MSW = dgot_pkg::MsqTotW;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [24:0] pixel_count_q;
  logic [4:0]  sample_bits_q;
  logic [8:0]  window_frames_q;
  logic [10:0] cut_threshold_q;
  logic [16:0] damping_q;
  logic        chroma_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q   <= 25'd2073600;
      sample_bits_q   <= 5'd8;
      window_frames_q <= 9'd30;
      cut_threshold_q <= 11'd768;
      damping_q       <= 17'd0;
      chroma_en_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (dgot_pkg::cfg_idx_e'(cfg_index_i))
        dgot_pkg::CFG_PIXEL_COUNT:   pixel_count_q   <= cfg_data_i;
        dgot_pkg::CFG_SAMPLE_BITS:   sample_bits_q   <= cfg_data_i[4:0];
        dgot_pkg::CFG_WINDOW_FRAMES: window_frames_q <= cfg_data_i[8:0];
        dgot_pkg::CFG_CUT_THRESHOLD: cut_threshold_q <= cfg_data_i[10:0];
        dgot_pkg::CFG_DAMPING:       damping_q       <= cfg_data_i[16:0];
        dgot_pkg::CFG_CHROMA_EN:     chroma_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Derived settings
  logic [24:0] pix_n;
  logic [4:0]  bits;
  logic [10:0] len11, wf11, dep11, cnt11, head11, tail11;
  logic [23:0] floor10, eps, den;
  logic [16:0] d_w, d_inv;

  assign pix_n = (pixel_count_q == '0) ? 25'd1 : pixel_count_q;
  assign bits  = (sample_bits_q < 5'd8) ? 5'd8 :
                 ((sample_bits_q > 5'd16) ? 5'd16 : sample_bits_q);
  assign floor10 = ((24'd1 << bits) - 24'd1) << 8;
  assign eps     = 24'd128 << (bits - 5'd8);
  assign d_w     = (damping_q > dgot_pkg::WOne) ? dgot_pkg::WOne : damping_q;
  assign d_inv   = dgot_pkg::WOne - d_w;
  assign wf11    = 11'(window_frames_q);
  assign dep11   = 11'(WINDOW_DEPTH);

  always_comb begin
    len11 = (wf11 < 11'd5) ? 11'd5 : wf11;
    if (len11 > dep11) len11 = dep11;
  end

  // ---------------------------------------------------------------------
  // State
  dgot_pkg::state_e state_q, state_d;

  logic [39:0] sum_q;
  logic [55:0] sumsq_q;
  logic [23:0] mean_q, sigma_q, wm_q, ws_q, rmu_q, rsig_q, g_q;
  logic [62:0] var_q;
  logic [47:0] m2_q, wsq_q;
  logic        cut_hi_q, cut_q;
  logic signed [35:0] o_q;
  logic signed [62:0] acc_q;

  logic [CW-1:0]  count_q;
  logic [HW-1:0]  head_q;
  logic [MTW-1:0] mean_tot_q, sig_tot_q;
  logic [MSW-1:0] msq_tot_q;
  logic [23:0]    prev_gain_q;
  logic signed [35:0] prev_off_q;
  logic           damp_valid_q;

  logic        out_valid_q;
  logic [23:0] out_gain_q;
  logic [35:0] out_off_q;
  logic        out_cut_q, out_chroma_q;

  assign cnt11  = 11'(count_q);
  assign head11 = 11'(head_q);
  assign tail11 = (head11 >= cnt11) ? (head11 - cnt11) : (head11 + dep11 - cnt11);
  assign den    = (sigma_q > eps) ? sigma_q : eps;

  // ---------------------------------------------------------------------
  // Window RAM: {sigma, mean}
  logic [47:0]   ring_mem [WINDOW_DEPTH];
  logic [47:0]   rd_q;
  logic          ring_we;
  logic [HW-1:0] tail;

  assign tail = tail11[HW-1:0];

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[head_q] <= {sigma_q, mean_q};
    rd_q <= ring_mem[tail];
  end

  // ---------------------------------------------------------------------
  // Shared restoring divider
  logic [6:0]  dv_cnt_q;
  logic [24:0] dv_rem_q, dv_dvs_q;
  logic [71:0] dv_quo_q;
  logic [25:0] dv_trial, dv_sub;
  logic        dv_ge, dv_busy, dv_go;
  logic [71:0] dv_in;
  logic [6:0]  dv_len;
  logic [24:0] dv_dvs;

  assign dv_busy  = (dv_cnt_q != '0);
  assign dv_trial = {dv_rem_q, dv_quo_q[71]};
  assign dv_sub   = dv_trial - {1'b0, dv_dvs_q};
  assign dv_ge    = (dv_trial >= {1'b0, dv_dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (dv_go) begin
      dv_cnt_q <= dv_len;
    end else if (dv_busy) begin
      dv_cnt_q <= dv_cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_go) begin
      dv_rem_q <= '0;
      dv_quo_q <= dv_in;
      dv_dvs_q <= dv_dvs;
    end else if (dv_busy) begin
      dv_rem_q <= dv_ge ? dv_sub[24:0] : dv_trial[24:0];
      dv_quo_q <= {dv_quo_q[70:0], dv_ge};
    end
  end

  // ---------------------------------------------------------------------
  // Shared square root, two radicand bits per step
  logic [5:0]  sq_cnt_q;
  logic [35:0] sq_rem_q;
  logic [31:0] sq_root_q;
  logic [63:0] sq_val_q;
  logic [35:0] sq_trem, sq_trial;
  logic        sq_ge, sq_busy, sq_go;
  logic [63:0] sq_in;

  assign sq_busy  = (sq_cnt_q != '0);
  assign sq_trem  = {sq_rem_q[33:0], sq_val_q[63:62]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = (sq_trem >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (sq_go) begin
      sq_cnt_q <= 6'd32;
    end else if (sq_busy) begin
      sq_cnt_q <= sq_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_go) begin
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_val_q  <= sq_in;
    end else if (sq_busy) begin
      sq_rem_q  <= sq_ge ? (sq_trem - sq_trial) : sq_trem;
      sq_root_q <= {sq_root_q[30:0], sq_ge};
      sq_val_q  <= {sq_val_q[61:0], 2'b00};
    end
  end

  // Unit handshake: started flag, done when the unit has gone idle again
  logic wait_q, unit_done;
  assign unit_done = wait_q && !dv_busy && !sq_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wait_q <= 1'b0;
    else if (dv_go || sq_go) wait_q <= 1'b1;
    else if (unit_done) wait_q <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shared multiplier, product registered
  logic signed [36:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [62:0] prod_d, prod_q;

  assign prod_d = mul_a * mul_b;
  always_ff @(posedge clk_i) prod_q <= prod_d;

  // ---------------------------------------------------------------------
  // Comparisons and small helpers
  logic [23:0] diff;
  logic        cut_now, drop_more, out_free;
  logic [47:0] wvar;
  logic signed [63:0] dsum;
  logic signed [47:0] dshift;
  logic [48:0] rnd;
  logic signed [37:0] off_raw;

  assign diff      = (mean_q > wm_q) ? (mean_q - wm_q) : (wm_q - mean_q);
  assign cut_now   = (ws_q != '0) && cut_hi_q && ($unsigned(prod_q) > 63'(floor10));
  assign drop_more = (count_q != '0) && (cnt11 >= len11);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign wvar      = (wsq_q > prod_q[47:0]) ? (wsq_q - prod_q[47:0]) : 48'd0;
  assign dsum      = 64'(acc_q) + 64'(prod_q) + 64'sd32768;
  assign dshift    = dsum[63:16];
  assign rnd       = 49'(prod_q[47:0]) + 49'd32768;
  assign off_raw   = $signed({14'd0, rmu_q}) - $signed({5'd0, rnd[48:16]});

  function automatic logic signed [35:0] sat_off(input logic signed [47:0] v);
    if (v > 48'sd34359738367) sat_off = 36'sh7_FFFF_FFFF;
    else if (v < -48'sd34359738368) sat_off = 36'sh8_0000_0000;
    else sat_off = v[35:0];
  endfunction

  function automatic logic [23:0] sat24(input logic [31:0] v);
    sat24 = (v > 32'(dgot_pkg::Q24Max)) ? dgot_pkg::Q24Max : v[23:0];
  endfunction

  // ---------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dgot_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = dgot_pkg::ST_MEAN;
      dgot_pkg::ST_MEAN:   if (unit_done) state_d = dgot_pkg::ST_EX2;
      dgot_pkg::ST_EX2:    if (unit_done) state_d = dgot_pkg::ST_M2;
      dgot_pkg::ST_M2:     state_d = dgot_pkg::ST_VAR;
      dgot_pkg::ST_VAR:    state_d = dgot_pkg::ST_SIG;
      dgot_pkg::ST_SIG:
        if (unit_done) state_d = (cnt11 >= 11'd5) ? dgot_pkg::ST_WM : dgot_pkg::ST_DROP;
      dgot_pkg::ST_WM:     if (unit_done) state_d = dgot_pkg::ST_WSQ;
      dgot_pkg::ST_WSQ:    if (unit_done) state_d = dgot_pkg::ST_WM2;
      dgot_pkg::ST_WM2:    state_d = dgot_pkg::ST_WS;
      dgot_pkg::ST_WS:     if (unit_done) state_d = dgot_pkg::ST_CUT1;
      dgot_pkg::ST_CUT1:   state_d = dgot_pkg::ST_CUT2;
      dgot_pkg::ST_CUT2:   state_d = dgot_pkg::ST_CUT3;
      dgot_pkg::ST_CUT3:   state_d = cut_now ? dgot_pkg::ST_FIN : dgot_pkg::ST_DROP;
      dgot_pkg::ST_DROP:   state_d = drop_more ? dgot_pkg::ST_DRD : dgot_pkg::ST_APPEND;
      dgot_pkg::ST_DRD:    state_d = dgot_pkg::ST_DSQ;
      dgot_pkg::ST_DSQ:    state_d = dgot_pkg::ST_DROP;
      dgot_pkg::ST_APPEND: state_d = dgot_pkg::ST_RMU;
      dgot_pkg::ST_RMU:    if (unit_done) state_d = dgot_pkg::ST_RSIG;
      dgot_pkg::ST_RSIG:   if (unit_done) state_d = dgot_pkg::ST_GDIV;
      dgot_pkg::ST_GDIV:   if (unit_done) state_d = dgot_pkg::ST_GSQ;
      dgot_pkg::ST_GSQ:    if (unit_done) state_d = dgot_pkg::ST_GM;
      dgot_pkg::ST_GM:     state_d = dgot_pkg::ST_OFF;
      dgot_pkg::ST_OFF:    state_d = damp_valid_q ? dgot_pkg::ST_D1 : dgot_pkg::ST_FIN;
      dgot_pkg::ST_D1:     state_d = dgot_pkg::ST_D2;
      dgot_pkg::ST_D2:     state_d = dgot_pkg::ST_D3;
      dgot_pkg::ST_D3:     state_d = dgot_pkg::ST_D4;
      dgot_pkg::ST_D4:     state_d = dgot_pkg::ST_D5;
      dgot_pkg::ST_D5:     state_d = dgot_pkg::ST_FIN;
      dgot_pkg::ST_FIN:    if (out_free) state_d = dgot_pkg::ST_IDLE;
      default:             state_d = dgot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dgot_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // ---------------------------------------------------------------------
  // Sequencer: unit operands and strobes
  always_comb begin
    dv_go   = 1'b0;
    sq_go   = 1'b0;
    dv_in   = '0;
    dv_len  = '0;
    dv_dvs  = 25'd1;
    sq_in   = '0;
    mul_a   = '0;
    mul_b   = '0;
    ring_we = 1'b0;
    unique case (state_q)
      dgot_pkg::ST_MEAN: begin
        dv_go = !wait_q; dv_in = {sum_q, 32'd0}; dv_len = 7'd48; dv_dvs = pix_n;
      end
      dgot_pkg::ST_EX2: begin
        dv_go = !wait_q; dv_in = {sumsq_q, 16'd0}; dv_len = 7'd72; dv_dvs = pix_n;
      end
      dgot_pkg::ST_M2: begin
        mul_a = $signed({13'd0, mean_q}); mul_b = $signed({2'd0, mean_q});
      end
      dgot_pkg::ST_SIG: begin
        sq_go = !wait_q; sq_in = {1'b0, var_q};
      end
      dgot_pkg::ST_WM: begin
        dv_go = !wait_q; dv_in = {mean_tot_q, 38'd0}; dv_len = 7'(MTW);
        dv_dvs = 25'(count_q);
      end
      dgot_pkg::ST_WSQ: begin
        dv_go = !wait_q; dv_in = {msq_tot_q, 14'd0}; dv_len = 7'(MSW);
        dv_dvs = 25'(count_q);
      end
      dgot_pkg::ST_WM2: begin
        mul_a = $signed({13'd0, wm_q}); mul_b = $signed({2'd0, wm_q});
      end
      dgot_pkg::ST_WS: begin
        sq_go = !wait_q; sq_in = {16'd0, wvar};
      end
      dgot_pkg::ST_CUT1: begin
        mul_a = $signed({13'd0, ws_q}); mul_b = $signed({15'd0, cut_threshold_q});
      end
      dgot_pkg::ST_CUT2: begin
        mul_a = $signed({13'd0, diff}); mul_b = 26'sd10;
      end
      dgot_pkg::ST_DRD: begin
        mul_a = $signed({13'd0, rd_q[23:0]}); mul_b = $signed({2'd0, rd_q[23:0]});
      end
      dgot_pkg::ST_APPEND: ring_we = 1'b1;
      dgot_pkg::ST_RMU: begin
        dv_go = !wait_q; dv_in = {mean_tot_q, 38'd0}; dv_len = 7'(MTW);
        dv_dvs = 25'(count_q);
      end
      dgot_pkg::ST_RSIG: begin
        dv_go = !wait_q; dv_in = {sig_tot_q, 38'd0}; dv_len = 7'(MTW);
        dv_dvs = 25'(count_q);
      end
      dgot_pkg::ST_GDIV: begin
        dv_go = !wait_q; dv_in = {rsig_q, 48'd0}; dv_len = 7'd56; dv_dvs = 25'(den);
      end
      dgot_pkg::ST_GSQ: begin
        sq_go = !wait_q; sq_in = {8'd0, dv_quo_q[55:0]};
      end
      dgot_pkg::ST_GM: begin
        mul_a = $signed({13'd0, g_q}); mul_b = $signed({2'd0, mean_q});
      end
      dgot_pkg::ST_D1: begin
        mul_a = $signed({13'd0, prev_gain_q}); mul_b = $signed({9'd0, d_w});
      end
      dgot_pkg::ST_D2: begin
        mul_a = $signed({13'd0, g_q}); mul_b = $signed({9'd0, d_inv});
      end
      dgot_pkg::ST_D3: begin
        mul_a = {prev_off_q[35], prev_off_q}; mul_b = $signed({9'd0, d_w});
      end
      dgot_pkg::ST_D4: begin
        mul_a = {o_q[35], o_q}; mul_b = $signed({9'd0, d_inv});
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      dgot_pkg::ST_IDLE:
        if (s_axis_tvalid) begin
          sum_q    <= s_axis_tdata[39:0];
          sumsq_q  <= s_axis_tdata[95:40];
          cut_q    <= 1'b0;
          cut_hi_q <= 1'b0;
        end
      dgot_pkg::ST_MEAN:
        if (unit_done)
          mean_q <= (dv_quo_q > 72'(dgot_pkg::Q24Max)) ? dgot_pkg::Q24Max : dv_quo_q[23:0];
      dgot_pkg::ST_EX2:
        if (unit_done)
          var_q <= (dv_quo_q >= (72'd1 << 62)) ? (63'd1 << 62) : dv_quo_q[62:0];
      dgot_pkg::ST_VAR: begin
        m2_q  <= prod_q[47:0];
        var_q <= (var_q > 63'(prod_q[47:0])) ? (var_q - 63'(prod_q[47:0])) : 63'd0;
      end
      dgot_pkg::ST_SIG:    if (unit_done) sigma_q <= sat24(sq_root_q);
      dgot_pkg::ST_WM:     if (unit_done) wm_q <= dv_quo_q[23:0];
      dgot_pkg::ST_WSQ:    if (unit_done) wsq_q <= dv_quo_q[47:0];
      dgot_pkg::ST_WS:     if (unit_done) ws_q <= sq_root_q[23:0];
      dgot_pkg::ST_CUT2:   cut_hi_q <= (63'({diff, 8'd0}) > $unsigned(prod_q));
      dgot_pkg::ST_CUT3:   cut_q <= cut_now;
      dgot_pkg::ST_RMU:    if (unit_done) rmu_q <= dv_quo_q[23:0];
      dgot_pkg::ST_RSIG:   if (unit_done) rsig_q <= dv_quo_q[23:0];
      dgot_pkg::ST_GSQ:    if (unit_done) g_q <= sat24(sq_root_q);
      dgot_pkg::ST_OFF:    o_q <= sat_off(48'(off_raw));
      dgot_pkg::ST_D2:     acc_q <= prod_q;
      dgot_pkg::ST_D3:
        if (dshift < 48'sd0) g_q <= '0;
        else g_q <= (dshift > 48'sd16777215) ? dgot_pkg::Q24Max : dshift[23:0];
      dgot_pkg::ST_D4:     acc_q <= prod_q;
      dgot_pkg::ST_D5:     o_q <= sat_off(dshift);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Window bookkeeping and damping history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      head_q       <= '0;
      mean_tot_q   <= '0;
      msq_tot_q    <= '0;
      sig_tot_q    <= '0;
      prev_gain_q  <= dgot_pkg::GainOne;
      prev_off_q   <= '0;
      damp_valid_q <= 1'b0;
    end else begin
      case (state_q)
        dgot_pkg::ST_DRD: begin
          mean_tot_q <= mean_tot_q - MTW'(rd_q[23:0]);
          sig_tot_q  <= sig_tot_q - MTW'(rd_q[47:24]);
        end
        dgot_pkg::ST_DSQ: begin
          msq_tot_q <= msq_tot_q - MSW'(prod_q[47:0]);
          count_q   <= count_q - CW'(1);
        end
        dgot_pkg::ST_APPEND: begin
          head_q     <= (head11 == dep11 - 11'd1) ? '0 : head_q + HW'(1);
          count_q    <= count_q + CW'(1);
          mean_tot_q <= mean_tot_q + MTW'(mean_q);
          msq_tot_q  <= msq_tot_q + MSW'(m2_q);
          sig_tot_q  <= sig_tot_q + MTW'(sigma_q);
        end
        dgot_pkg::ST_FIN:
          if (out_free && !cut_q) begin
            prev_gain_q  <= g_q;
            prev_off_q   <= o_q;
            damp_valid_q <= 1'b1;
          end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == dgot_pkg::ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dgot_pkg::ST_FIN && out_free) begin
      out_cut_q    <= cut_q;
      out_gain_q   <= cut_q ? dgot_pkg::GainOne : g_q;
      out_off_q    <= cut_q ? 36'd0 : o_q;
      out_chroma_q <= cut_q ? 1'b0 : chroma_en_q;
    end
  end

  assign s_axis_tready = (state_q == dgot_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_off_q, out_gain_q};
  assign m_axis_tuser  = {out_chroma_q, out_cut_q};

endmodule
